@@ hw/rtl/gget_pkg.sv @@
// ----------------------------------------------------------------------------
// gget_pkg
// Shared widths, constants and types of the gray gradient edge threshold block.
// ----------------------------------------------------------------------------
package gget_pkg;

  localparam int MAX_LINE_DEF = 2048;

  localparam int PIX_W     = 8;
  localparam int COLS_W    = 12;
  localparam int ROWS_W    = 13;
  localparam int THR_W     = 16;
  localparam int ROW_W     = 12;
  localparam int COL_OUT_W = 11;
  localparam int ROW_LIMIT = 4096;

  localparam logic [COLS_W-1:0] COLS_RESET = 12'd640;
  localparam logic [ROWS_W-1:0] ROWS_RESET = 13'd480;
  localparam logic [THR_W-1:0]  THR_RESET  = 16'd0;

  // Luma weights in percent, and a reciprocal of 100 that is exact for sums
  // up to 25500.
  localparam int WSUM_W = 15;
  localparam logic [WSUM_W-1:0] W_RED   = 15'd30;
  localparam logic [WSUM_W-1:0] W_GREEN = 15'd59;
  localparam logic [WSUM_W-1:0] W_BLUE  = 15'd11;
  localparam int PROD_W      = 2 * WSUM_W;
  localparam int RECIP_SHIFT = 21;
  localparam logic [PROD_W-1:0] RECIP = 30'd20972;

  localparam logic [PIX_W-1:0] LEVEL_EDGE = 8'd0;
  localparam logic [PIX_W-1:0] LEVEL_FLAT = 8'd255;

  localparam int SQ_W   = 16;
  localparam int SUM_W  = SQ_W + 1;
  localparam int MAG_W  = SUM_W + 6;
  localparam int T2_W   = 2 * THR_W;

  localparam int FQ_DEPTH = 8;
  localparam int FQ_AW    = 3;
  localparam int FQ_CW    = 4;

  localparam int APB_AW = 4;
  localparam int APB_DW = 32;

  typedef enum logic [1:0] {
    REG_FRAME_COLS = 2'd0,
    REG_FRAME_ROWS = 2'd1,
    REG_EDGE_THR   = 2'd2
  } reg_idx_t;

  // One classified pixel handed from the front to the back.
  typedef struct packed {
    logic              above;
    logic              own;
    logic              interior;
    logic              last_col;
    logic [SQ_W-1:0]   sq_x;
    logic [SQ_W-1:0]   sq_y;
    logic [PIX_W-1:0]  center;
    logic [PIX_W-1:0]  gray;
    logic [ROW_W-1:0]  row;
    logic [COLS_W-1:0] col;
  } fq_entry_t;

endpackage

@@ hw/rtl/gget_ram.sv @@
// ----------------------------------------------------------------------------
// gget_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module gget_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // A read of the address being written returns the old contents.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hw/rtl/gget_queue.sv @@
// ----------------------------------------------------------------------------
// gget_queue
// Short queue of classified pixels between the front and the back.
// ----------------------------------------------------------------------------
module gget_queue
  import gget_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  fq_entry_t        push_data,
  input  logic             pop,
  output fq_entry_t        head,
  output logic             not_empty,
  output logic [FQ_CW-1:0] count
);

  fq_entry_t        mem_r [FQ_DEPTH];
  logic [FQ_AW-1:0] wp_r, rp_r;
  logic [FQ_CW-1:0] count_r, count_nxt;

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + FQ_CW'(1);
    end else if (!push && pop) begin
      count_nxt = count_r - FQ_CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r    <= '0;
      rp_r    <= '0;
      count_r <= '0;
    end else begin
      if (push) begin
        wp_r <= wp_r + FQ_AW'(1);
      end
      if (pop) begin
        rp_r <= rp_r + FQ_AW'(1);
      end
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_data;
    end
  end

  assign head      = mem_r[rp_r];
  assign not_empty = (count_r != '0);
  assign count     = count_r;

endmodule

@@ hw/rtl/gget_front.sv @@
// ----------------------------------------------------------------------------
// gget_front
// Accepts pixels, tracks the raster position, converts to gray, keeps the two
// line buffers and forms the squared central differences.
// ----------------------------------------------------------------------------
module gget_front
  import gget_pkg::*;
#(
  parameter int MAX_LINE = MAX_LINE_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  output logic              full,
  input  logic [PIX_W-1:0]  red,
  input  logic [PIX_W-1:0]  green,
  input  logic [PIX_W-1:0]  blue,
  input  logic [COLS_W-1:0] eff_cols,
  input  logic [ROWS_W-1:0] eff_rows,
  input  logic              restart,
  input  logic [FQ_CW-1:0]  q_count,
  output logic              q_push,
  output fq_entry_t         q_data
);

  localparam int AW = (MAX_LINE > 1) ? $clog2(MAX_LINE) : 1;
  localparam int LW = FQ_CW + 1;

  typedef struct packed {
    logic              above;
    logic              own;
    logic              interior;
    logic              has_right;
    logic              last_col;
    logic              one_col;
    logic [ROW_W-1:0]  row;
    logic [COLS_W-1:0] col;
    logic [COLS_W-1:0] rd_col;
  } meta_t;

  logic              acc;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [COLS_W-1:0] col_r, col_nxt;
  logic [ROW_W:0]    row_p1;
  logic [COLS_W:0]   col_p1;
  meta_t             meta_in;

  logic              s0_v_r, s1_v_r, s2_v_r, s3_v_r;
  meta_t             s0_m_r, s1_m_r, s2_m_r, s3_m_r;
  logic [PIX_W-1:0]  s0_red_r, s0_green_r, s0_blue_r;
  logic [WSUM_W-1:0] s1_wsum_r;
  logic [PIX_W-1:0]  s2_gray_r;
  logic [PIX_W-1:0]  s3_gray_r, s3_center_r, s3_left_r;
  logic [PIX_W-1:0]  left_r, last_gray_r;

  logic [WSUM_W-1:0] wsum;
  logic [PROD_W-1:0] prod;
  logic [PIX_W-1:0]  center;
  logic [PIX_W-1:0]  mid_rdata, up_rdata;
  logic [PIX_W-1:0]  right;
  logic signed [PIX_W:0]     dx, dy;
  logic signed [2*PIX_W+1:0] sqx, sqy;
  logic [LW-1:0]     load;

  // Credit check: every pixel in the front stages has a queue slot reserved.
  assign load = LW'(q_count) + LW'(s0_v_r) + LW'(s1_v_r) + LW'(s2_v_r) + LW'(s3_v_r);
  assign full = (load >= LW'(FQ_DEPTH));
  assign acc  = push && !full;

  assign row_p1 = {1'b0, row_r} + (ROW_W+1)'(1);
  assign col_p1 = {1'b0, col_r} + (COLS_W+1)'(1);

  always_comb begin
    meta_in           = '0;
    meta_in.above     = (row_r != '0);
    meta_in.own       = ((ROWS_W)'(row_p1) == eff_rows);
    meta_in.has_right = (col_p1 < {1'b0, eff_cols});
    meta_in.last_col  = (col_p1 == {1'b0, eff_cols});
    meta_in.interior  = (row_r >= ROW_W'(2)) && (col_r != '0) && meta_in.has_right;
    meta_in.one_col   = (eff_cols == COLS_W'(1));
    meta_in.row       = row_r;
    meta_in.col       = col_r;
    // At the end of a row the next read fetches column 0 for the next row.
    meta_in.rd_col    = meta_in.has_right ? col_p1[COLS_W-1:0] : '0;
  end

  always_comb begin
    row_nxt = row_r;
    col_nxt = col_r;
    if (restart) begin
      row_nxt = '0;
      col_nxt = '0;
    end else if (acc) begin
      if (meta_in.last_col) begin
        col_nxt = '0;
        row_nxt = meta_in.own ? '0 : row_p1[ROW_W-1:0];
      end else begin
        col_nxt = col_p1[COLS_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r  <= '0;
      col_r  <= '0;
      s0_v_r <= 1'b0;
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else begin
      row_r  <= row_nxt;
      col_r  <= col_nxt;
      s0_v_r <= acc;
      s1_v_r <= s0_v_r;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
    end
  end

  assign wsum = W_RED * WSUM_W'(s0_red_r) + W_GREEN * WSUM_W'(s0_green_r)
              + W_BLUE * WSUM_W'(s0_blue_r);
  assign prod = PROD_W'(s1_wsum_r) * RECIP;

  // Column 0 of a one-column frame was written by the pixel just before.
  assign center = s2_m_r.one_col ? last_gray_r : mid_rdata;

  always_ff @(posedge clk) begin
    s0_m_r     <= meta_in;
    s0_red_r   <= red;
    s0_green_r <= green;
    s0_blue_r  <= blue;
    s1_m_r     <= s0_m_r;
    s1_wsum_r  <= wsum;
    s2_m_r     <= s1_m_r;
    s2_gray_r  <= prod[RECIP_SHIFT+PIX_W-1:RECIP_SHIFT];
    s3_m_r     <= s2_m_r;
    s3_gray_r  <= s2_gray_r;
    s3_center_r <= center;
    s3_left_r  <= left_r;
    if (s2_v_r) begin
      left_r      <= center;
      last_gray_r <= s2_gray_r;
    end
  end

  gget_ram #(
    .WIDTH (PIX_W),
    .DEPTH (MAX_LINE)
  ) u_mid_line (
    .clk   (clk),
    .we    (s2_v_r),
    .waddr (AW'(s2_m_r.col)),
    .wdata (s2_gray_r),
    .re    (s2_v_r),
    .raddr (AW'(s2_m_r.rd_col)),
    .rdata (mid_rdata)
  );

  gget_ram #(
    .WIDTH (PIX_W),
    .DEPTH (MAX_LINE)
  ) u_up_line (
    .clk   (clk),
    .we    (s2_v_r),
    .waddr (AW'(s2_m_r.col)),
    .wdata (center),
    .re    (s2_v_r),
    .raddr (AW'(s2_m_r.col)),
    .rdata (up_rdata)
  );

  assign right = s3_m_r.has_right ? mid_rdata : '0;
  assign dx    = $signed({1'b0, right}) - $signed({1'b0, s3_left_r});
  assign dy    = $signed({1'b0, s3_gray_r}) - $signed({1'b0, up_rdata});
  assign sqx   = dx * dx;
  assign sqy   = dy * dy;

  // Pixels of the first row only fill the line buffers, unless it is also the last row.
  assign q_push = s3_v_r && (s3_m_r.above || s3_m_r.own);

  always_comb begin
    q_data          = '0;
    q_data.above    = s3_m_r.above;
    q_data.own      = s3_m_r.own;
    q_data.interior = s3_m_r.interior;
    q_data.last_col = s3_m_r.last_col;
    q_data.sq_x     = sqx[SQ_W-1:0];
    q_data.sq_y     = sqy[SQ_W-1:0];
    q_data.center   = s3_center_r;
    q_data.gray     = s3_gray_r;
    q_data.row      = s3_m_r.row;
    q_data.col      = s3_m_r.col;
  end

endmodule

@@ hw/rtl/gget_back.sv @@
// ----------------------------------------------------------------------------
// gget_back
// Applies the threshold and emits one or two results per queued pixel
// through an output register.
// ----------------------------------------------------------------------------
module gget_back
  import gget_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_valid,
  input  fq_entry_t            q_head,
  output logic                 q_pop,
  input  logic [T2_W-1:0]      t2,
  input  logic                 pop,
  output logic                 empty,
  output logic [PIX_W-1:0]     level,
  output logic [ROW_W-1:0]     row,
  output logic [COL_OUT_W-1:0] col,
  output logic                 frame_end
);

  logic                 phase_r, phase_nxt;
  logic                 out_v_r, out_v_nxt;
  logic [PIX_W-1:0]     level_r;
  logic [ROW_W-1:0]     row_r;
  logic [COL_OUT_W-1:0] col_r;
  logic                 frame_end_r;

  logic                 emit_above, entry_done, take, edge_hit;
  logic [SUM_W-1:0]     sumsq;
  logic [MAG_W-1:0]     mag;
  logic [PIX_W-1:0]     res_level;
  logic [ROW_W-1:0]     res_row;
  logic                 res_end;

  assign sumsq    = SUM_W'(q_head.sq_x) + SUM_W'(q_head.sq_y);
  assign mag      = {sumsq, 6'd0};
  assign edge_hit = (T2_W'(mag) > t2);

  // The pixel one row up goes out before the last row's own pixel.
  assign emit_above = q_head.above && !phase_r;
  assign entry_done = emit_above ? !q_head.own : 1'b1;

  always_comb begin
    if (emit_above) begin
      res_row = q_head.row - ROW_W'(1);
      res_end = 1'b0;
      if (q_head.interior) begin
        res_level = edge_hit ? LEVEL_EDGE : LEVEL_FLAT;
      end else begin
        res_level = q_head.center;
      end
    end else begin
      res_level = q_head.gray;
      res_row   = q_head.row;
      res_end   = q_head.last_col;
    end
  end

  assign take  = q_valid && (!out_v_r || pop);
  assign q_pop = take && entry_done;

  always_comb begin
    phase_nxt = phase_r;
    out_v_nxt = out_v_r;
    if (take) begin
      phase_nxt = !entry_done;
      out_v_nxt = 1'b1;
    end else if (pop) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      level_r     <= res_level;
      row_r       <= res_row;
      col_r       <= q_head.col[COL_OUT_W-1:0];
      frame_end_r <= res_end;
    end
  end

  assign empty     = !out_v_r;
  assign level     = level_r;
  assign row       = row_r;
  assign col       = col_r;
  assign frame_end = frame_end_r;

endmodule

@@ hw/rtl/gray_gradient_edge_threshold.sv @@
// ----------------------------------------------------------------------------
// gray_gradient_edge_threshold
// Raster RGB to gray, central difference gradient and threshold, one row late.
// ----------------------------------------------------------------------------
//
//   channel   handshake           payload
//   -------   -----------------   ----------------------------------------
//   pixel in  push / full         in_red, in_green, in_blue
//   result    empty / pop         out_level, out_row, out_col, out_frame_end
//   config    psel/penable/pwrite paddr, pwdata, prdata, pready
//
// One pixel is taken per clock while full is low. In the last row of a frame
// with more than one row every pixel gives two results and the result port
// moves one transfer per clock while pop is held, so full holds pixels back
// in that row. full rises when queued pixels plus those in the four front
// stages reach the 8-entry queue depth.
// Reset clears counters and loads the register defaults; line buffers keep
// their contents. Writing frame_cols or frame_rows restarts the frame.
// ----------------------------------------------------------------------------
module gray_gradient_edge_threshold
  import gget_pkg::*;
#(
  parameter int MAX_LINE = MAX_LINE_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  output logic                 full,
  input  logic [PIX_W-1:0]     in_red,
  input  logic [PIX_W-1:0]     in_green,
  input  logic [PIX_W-1:0]     in_blue,
  output logic                 empty,
  input  logic                 pop,
  output logic [PIX_W-1:0]     out_level,
  output logic [ROW_W-1:0]     out_row,
  output logic [COL_OUT_W-1:0] out_col,
  output logic                 out_frame_end,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [APB_AW-1:0]    paddr,
  input  logic [APB_DW-1:0]    pwdata,
  output logic [APB_DW-1:0]    prdata,
  output logic                 pready
);

  logic [COLS_W-1:0] frame_cols_r;
  logic [ROWS_W-1:0] frame_rows_r;
  logic [THR_W-1:0]  edge_thr_r;
  logic [T2_W-1:0]   t2_r;
  logic [COLS_W-1:0] eff_cols;
  logic [ROWS_W-1:0] eff_rows;
  logic              cfg_wr, restart;
  reg_idx_t          reg_idx;

  logic              q_push, q_pop, q_nonempty;
  logic [FQ_CW-1:0]  q_count;
  fq_entry_t         q_data, q_head;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign restart = cfg_wr && (reg_idx == REG_FRAME_COLS || reg_idx == REG_FRAME_ROWS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_cols_r <= COLS_RESET;
      frame_rows_r <= ROWS_RESET;
      edge_thr_r   <= THR_RESET;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_FRAME_COLS: frame_cols_r <= pwdata[COLS_W-1:0];
        REG_FRAME_ROWS: frame_rows_r <= pwdata[ROWS_W-1:0];
        REG_EDGE_THR:   edge_thr_r   <= pwdata[THR_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    t2_r <= T2_W'(edge_thr_r) * T2_W'(edge_thr_r);
  end

  always_comb begin
    case (reg_idx)
      REG_FRAME_COLS: prdata = APB_DW'(frame_cols_r);
      REG_FRAME_ROWS: prdata = APB_DW'(frame_rows_r);
      REG_EDGE_THR:   prdata = APB_DW'(edge_thr_r);
      default:        prdata = '0;
    endcase
  end

  // Zero acts as one; widths beyond the line buffer or row limit are capped.
  always_comb begin
    if (frame_cols_r == '0) begin
      eff_cols = COLS_W'(1);
    end else if (32'(frame_cols_r) > 32'(MAX_LINE)) begin
      eff_cols = COLS_W'(MAX_LINE);
    end else begin
      eff_cols = frame_cols_r;
    end
    if (frame_rows_r == '0) begin
      eff_rows = ROWS_W'(1);
    end else if (32'(frame_rows_r) > 32'(ROW_LIMIT)) begin
      eff_rows = ROWS_W'(ROW_LIMIT);
    end else begin
      eff_rows = frame_rows_r;
    end
  end

  gget_front #(
    .MAX_LINE (MAX_LINE)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .red      (in_red),
    .green    (in_green),
    .blue     (in_blue),
    .eff_cols (eff_cols),
    .eff_rows (eff_rows),
    .restart  (restart),
    .q_count  (q_count),
    .q_push   (q_push),
    .q_data   (q_data)
  );

  gget_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_data),
    .pop       (q_pop),
    .head      (q_head),
    .not_empty (q_nonempty),
    .count     (q_count)
  );

  gget_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_nonempty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .t2        (t2_r),
    .pop       (pop),
    .empty     (empty),
    .level     (out_level),
    .row       (out_row),
    .col       (out_col),
    .frame_end (out_frame_end)
  );

`ifndef NO_ASSERTIONS
  a_queue_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> (q_count < FQ_CW'(FQ_DEPTH)))
    else $error("queue push with no free slot");

  a_queue_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_nonempty)
    else $error("queue pop while empty");

  a_frame_end_last_row: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_frame_end) |-> ({1'b0, out_row} == (eff_rows - ROWS_W'(1))))
    else $error("frame end marked outside the last row");
`endif

endmodule
